// ===== hdl/smfm_pkg.sv =====
// Package with constants and field widths for the split-mantissa float multiplier.
`timescale 1ns / 1ps
`default_nettype none
package smfm_pkg;
  localparam int unsigned WordW   = 32;
  localparam int unsigned ExpW    = 8;
  localparam int unsigned HiW     = 13;
  localparam int unsigned LoW     = 11;
  localparam int unsigned SumW    = 27;
  localparam int unsigned EpreW   = 10;
  localparam logic [EpreW-1:0] ExpOffset = 10'd129;
  localparam logic [SumW-1:0]  RoundAdd  = 27'd2;
  localparam logic [ExpW-1:0]  ExpMax    = 8'd255;
  localparam logic [1:0] TopUnder = 2'b01;
  localparam logic [1:0] TopOver  = 2'b00;

  typedef struct packed {
    logic            zero;
    logic            sign;
    logic [EpreW-1:0] epre;
  } side_t;
endpackage
`default_nettype wire

// ===== hdl/smfm_mul_stage.sv =====
// Registered partial-product stage: three narrow multiplies with side data.
`timescale 1ns / 1ps
`default_nettype none
module smfm_mul_stage (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     vld_in,
  input  wire logic [smfm_pkg::HiW-1:0] ha,
  input  wire logic [smfm_pkg::HiW-1:0] hb,
  input  wire logic [smfm_pkg::LoW-1:0] la,
  input  wire logic [smfm_pkg::LoW-1:0] lb,
  input  wire smfm_pkg::side_t          side_in,
  output logic                          vld_out,
  output logic [2*smfm_pkg::HiW-1:0]    hh_out,
  output logic [smfm_pkg::HiW+smfm_pkg::LoW-1:0] hl_out,
  output logic [smfm_pkg::HiW+smfm_pkg::LoW-1:0] lh_out,
  output smfm_pkg::side_t               side_out
);
  import smfm_pkg::*;
  logic vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end
  always_ff @(posedge clk) begin
    hh_out   <= ha * hb;
    hl_out   <= ha * lb;
    lh_out   <= la * hb;
    side_out <= side_in;
  end
  assign vld_out = vld_r;
endmodule
`default_nettype wire

// ===== hdl/split_mantissa_float_multiplier_unit.sv =====
// Top level of the split-mantissa single-precision float multiplier.
// A start beat passes the operand-decode, multiply and output registers before its out_valid strobe.
// Throughput: one beat per cycle; busy is always low.
// Stages: operand decode, partial-product multiply, sum, normalise and pack.
// Reset: rst_n is synchronous and clears the valid bits of every stage.
`timescale 1ns / 1ps
`default_nettype none
module split_mantissa_float_multiplier_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [smfm_pkg::WordW-1:0]  in_operand_a,
  input  wire logic [smfm_pkg::WordW-1:0]  in_operand_b,
  output logic                             out_valid,
  output logic [smfm_pkg::WordW-1:0]       out_product
);
  import smfm_pkg::*;

  logic                 s1_vld_r;
  logic [HiW-1:0]       ha_r, hb_r;
  logic [LoW-1:0]       la_r, lb_r;
  side_t                side1_r;
  logic [ExpW-1:0]      ea, eb;

  assign busy = 1'b0;
  assign ea = in_operand_a[30:23];
  assign eb = in_operand_b[30:23];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
  end
  always_ff @(posedge clk) begin
    ha_r <= {(ea != '0), in_operand_a[22:11]};
    hb_r <= {(eb != '0), in_operand_b[22:11]};
    la_r <= in_operand_a[10:0];
    lb_r <= in_operand_b[10:0];
    side1_r.zero <= (in_operand_a == '0) || (in_operand_b == '0);
    side1_r.sign <= in_operand_a[31] ^ in_operand_b[31];
    side1_r.epre <= {2'b00, ea} + {2'b00, eb} + ExpOffset;
  end

  logic                   s2_vld;
  logic [2*HiW-1:0]       hh;
  logic [HiW+LoW-1:0]     hl, lh;
  side_t                  side2;

  smfm_mul_stage u_mul (
    .clk(clk), .rst_n(rst_n), .vld_in(s1_vld_r),
    .ha(ha_r), .hb(hb_r), .la(la_r), .lb(lb_r), .side_in(side1_r),
    .vld_out(s2_vld), .hh_out(hh), .hl_out(hl), .lh_out(lh), .side_out(side2)
  );

  logic [SumW-1:0] sum_nxt;
  logic            carry;
  logic [1:0]      top;
  logic [22:0]     mant;
  logic [ExpW-1:0] exp_f;
  logic [EpreW-1:0] epre_inc;
  logic            vld_r;
  logic [WordW-1:0] prod_r;

  always_comb begin
    sum_nxt  = {1'b0, hh} + {{(SumW-HiW-LoW+LoW){1'b0}}, hl[HiW+LoW-1:LoW]}
             + {{(SumW-HiW-LoW+LoW){1'b0}}, lh[HiW+LoW-1:LoW]} + RoundAdd;
    carry    = sum_nxt[25];
    top      = side2.epre[8:7];
    mant     = carry ? sum_nxt[24:2] : sum_nxt[23:1];
    epre_inc = side2.epre + 10'd1;
    if (top == TopUnder) begin
      exp_f = '0;
    end else if (top == TopOver) begin
      exp_f = ExpMax;
    end else if (carry) begin
      exp_f = epre_inc[ExpW-1:0];
    end else begin
      exp_f = side2.epre[ExpW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s2_vld;
    end
  end
  always_ff @(posedge clk) begin
    prod_r <= side2.zero ? '0 : {side2.sign, exp_f, mant};
  end

  assign out_valid   = vld_r;
  assign out_product = prod_r;
endmodule
`default_nettype wire

// ===== hdl/smfm_checker.sv =====
// Port-level checker for the float multiplier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module smfm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [31:0] in_operand_a,
  input wire logic [31:0] in_operand_b,
  input wire logic        out_valid,
  input wire logic [31:0] out_product
);
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid) else $error("missing result beat");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 3)) else $error("unexpected result beat");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && (in_operand_a == 32'd0 || in_operand_b == 32'd0))
      |-> ##3 (out_product == 32'd0))
    else $error("zero operand gave nonzero product");
endmodule

bind split_mantissa_float_multiplier_unit smfm_checker u_smfm_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
  .out_valid(out_valid), .out_product(out_product)
);
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the split-mantissa single-precision float multiplier.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import smfm_pkg::*;

  localparam int NumRandom = 1830;
  localparam int CycleLimit = 200000;

  typedef struct {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic             known;
    logic [WordW-1:0] product;
  } vector_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [WordW-1:0] in_operand_a;
  logic [WordW-1:0] in_operand_b;
  logic out_valid;
  logic [WordW-1:0] out_product;

  logic [WordW-1:0] product_queue[$];
  int mismatches = 0;
  int table_errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  vector_t vectors[$];

  split_mantissa_float_multiplier_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_product(out_product)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [WordW-1:0] float_product(logic [WordW-1:0] a, logic [WordW-1:0] b);
    logic [ExpW-1:0] ea, eb, e;
    logic [HiW-1:0] ha, hb;
    logic [LoW-1:0] la, lb;
    logic [SumW-1:0] sum;
    logic [EpreW-1:0] epre, eplus;
    logic [22:0] mant;
    logic [1:0] top;
    ea = a[30:23];
    eb = b[30:23];
    ha = {(ea != '0), a[22:11]};
    hb = {(eb != '0), b[22:11]};
    la = a[10:0];
    lb = b[10:0];
    sum = SumW'(ha) * SumW'(hb) + ((SumW'(ha) * SumW'(lb)) >> 11)
        + ((SumW'(la) * SumW'(hb)) >> 11) + RoundAdd;
    epre = EpreW'(ea) + EpreW'(eb) + ExpOffset;
    eplus = epre + 10'd1;
    top = epre[8:7];
    mant = sum[25] ? sum[24:2] : sum[23:1];
    if (top == TopUnder) e = '0;
    else if (top == TopOver) e = ExpMax;
    else if (sum[25]) e = eplus[7:0];
    else e = epre[7:0];
    if (a == '0 || b == '0) return '0;
    return {a[31] ^ b[31], e, mant};
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n && start && !busy) product_queue.push_back(float_product(in_operand_a, in_operand_b));
    if (rst_n && out_valid) begin
      if (product_queue.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected result beat: product %h", out_product);
      end else begin
        if (out_product !== product_queue[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Product mismatch: expected %h, actual %h", product_queue[0], out_product);
        end
        void'(product_queue.pop_front());
      end
    end
  end

  task automatic send_beat(logic [WordW-1:0] a, logic [WordW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [WordW-1:0] random_float();
    logic [WordW-1:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0: w[30:23] = '0;
      1: w[30:23] = 8'hFF;
      2: w[30:23] = 8'(63 + $urandom_range(3));
      3: w[30:23] = 8'(190 + $urandom_range(3));
      4: w = '0;
      default: w[30:23] = 8'(100 + $urandom_range(55));
    endcase
    return w;
  endfunction

  task automatic add_row(logic [WordW-1:0] a, logic [WordW-1:0] b, logic known,
                         logic [WordW-1:0] p);
    vector_t v;
    v.a = a;
    v.b = b;
    v.known = known;
    v.product = p;
    vectors.push_back(v);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_operand_a = '0;
    in_operand_b = '0;
    add_row(32'h0000_0000, 32'h3F80_0000, 1'b1, 32'h0000_0000);
    add_row(32'hBF80_0000, 32'h0000_0000, 1'b1, 32'h0000_0000);
    add_row(32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000);
    add_row(32'h8000_0000, 32'h3F80_0000, 1'b0, '0);
    add_row(32'h3F80_0000, 32'h3F80_0000, 1'b0, '0);
    add_row(32'h3FFF_FFFF, 32'h3FFF_FFFF, 1'b0, '0);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0, '0);
    add_row(32'h0080_0000, 32'h0080_0000, 1'b0, '0);
    add_row(32'h0000_0001, 32'h0000_0001, 1'b0, '0);
    add_row(32'h007F_FFFF, 32'h3F80_0000, 1'b0, '0);
    add_row(32'h7F80_0000, 32'h3F80_0000, 1'b0, '0);
    add_row(32'h7FC0_0000, 32'hC000_0000, 1'b0, '0);
    add_row(32'h2000_0000, 32'h1F00_0000, 1'b0, '0);
    add_row(32'h5F00_0000, 32'h6000_0000, 1'b0, '0);
    add_row(32'h4000_0000, 32'h4000_0000, 1'b0, '0);
    add_row(32'h3FC0_0000, 32'h3FC0_0000, 1'b0, '0);
    add_row(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (vectors[i]) begin
      send_beat(vectors[i].a, vectors[i].b);
      if (vectors[i].known && float_product(vectors[i].a, vectors[i].b) !== vectors[i].product) begin
        table_errors++;
        $display("Row %0d: predicted %h, table %h", i,
                 float_product(vectors[i].a, vectors[i].b), vectors[i].product);
      end
    end
    start <= 1'b0;
    while (product_queue.size() != 0) @(negedge clk);
    for (int n = 0; n < NumRandom; n++) begin
      case ((n * 4) / NumRandom)
        0: idle_pct = 0;
        1: idle_pct = 55;
        2: idle_pct = 21;
        default: idle_pct = (n % 200 < 100) ? 0 : 55;
      endcase
      send_beat(random_float(), random_float());
    end
    start <= 1'b0;
    while (product_queue.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && table_errors == 0 && product_queue.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
